// ----- design/arnm_pkg.sv -----
// Shared types and constants of the {a,b} regex matcher.
// No dependencies; every other file of the block but arnm_carry_chain imports this package.
package arnm_pkg;

    // Request codes carried in the op field.
    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_PAT   = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_SUBJ  = 3'd3;
    localparam logic [2:0] OP_END   = 3'd4;

    // Characters the pattern and subject parsers look for.
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    typedef enum logic [1:0] {
        Q_NONE = 2'd0,
        Q_STAR = 2'd1,
        Q_PLUS = 2'd2,
        Q_OPT  = 2'd3
    } t_quant;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
    } t_req;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_rsp;

endpackage

// ----- design/arnm_ifs.sv -----
// Valid/ready channel interfaces for the matcher's request and response streams.
// Depends on arnm_pkg for the payload structs.
interface arnm_req_if import arnm_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arnm_rsp_if import arnm_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/arnm_carry_chain.sv -----
// Prefix chain c[j] = g[j] | (p[j] & c[j-1]), c[-1] = 0, built on one adder.
// No dependencies.
module arnm_carry_chain #(
    parameter int W = 32
) (
    input  logic [W-1:0] i_gen,
    input  logic [W-1:0] i_prop,
    output logic [W-1:0] o_carry
);

    logic [W-1:0] opnd_a;
    logic [W-1:0] opnd_b;
    logic [W-1:0] sum;
    logic [W-1:0] carry_in;

    // a&b = g and a^b = p&~g, so the adder's carries follow the chain exactly.
    assign opnd_a  = i_gen | i_prop;
    assign opnd_b  = i_gen;
    assign sum     = opnd_a + opnd_b;
    assign carry_in = sum ^ opnd_a ^ opnd_b;
    assign o_carry = i_gen | (i_prop & carry_in);

endmodule

// ----- design/ab_regex_nfa_matcher.sv -----
// Top level of the {a,b} regex matcher: pattern store, bit-parallel NFA update
// and accept logic. Depends on arnm_pkg, arnm_ifs and arnm_carry_chain.
//
// Usage: requests arrive on i_req (op, ch); results leave on o_rsp
// (matched, pattern_overflow). Load a pattern with OP_CLEAR followed by one
// OP_PAT request per pattern character, then feed a subject with OP_START,
// one OP_SUBJ per character and OP_END. Only OP_END produces a response.
// Pieces beyond MAX_PIECES are dropped and reported via pattern_overflow.
//
// Timing: a request is captured in the input register, evaluated in a single
// pass, and the response of an OP_END is registered in the response register.
// One request is taken per cycle unless an OP_END waits behind a held
// response; the per-character closure over skippable pieces is one carry chain
// across MAX_PIECES bits, and the accept check is a second one, which set the
// cycle time.
// Reset (synchronous, i_rst_n low) empties the pattern, clears all flags and
// drops any pending request or response. When the receiver stalls, the
// response register holds; requests that produce no response keep flowing,
// and an OP_END behind a held response waits in the input register, which
// drops i_req.ready until the response is taken.
module ab_regex_nfa_matcher import arnm_pkg::*; #(
    parameter int MAX_PIECES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    arnm_req_if.sink   i_req,
    arnm_rsp_if.source o_rsp
);

    localparam int N = MAX_PIECES;

    // Input stage
    logic r_in_valid;
    t_req r_in;

    // Pattern store: entries at or above the fill mark are never looked at.
    logic   [N-1:0] r_atom;
    t_quant         r_quant [N];
    logic   [N-1:0] r_alt_first;
    logic   [N-1:0] r_valid;        // thermometer fill mark, bit j = piece j stored

    // Pattern parser and subject state
    logic         r_empty_alt;
    logic         r_last_atom;
    logic         r_alt_has;
    logic         r_ovf;
    logic [N-1:0] r_consumed;
    logic         r_at_start;
    logic         r_bad;

    // Response register
    logic r_out_valid;
    t_rsp r_out;

    logic fire;
    logic is_end;

    logic [N-1:0] opens;
    logic [N-1:0] skip;
    logic [N-1:0] loops;
    logic [N-1:0] last_sel;
    logic [N-1:0] wr_sel;
    logic [N-1:0] pass_gen;
    logic [N-1:0] pass_prop;
    logic [N-1:0] pass;
    logic [N-1:0] atom_ok;
    logic [N-1:0] next_cons;
    logic [N-1:0] tail_gen_r;
    logic [N-1:0] tail_prop_r;
    logic [N-1:0] tail_r;
    logic [N-1:0] tail;
    logic         full;
    logic         want_b;
    logic         ch_ab;
    logic         ch_quant;
    logic         hit;
    t_quant       quant_code;

    // ---------------------------------------------------------------
    // Handshake: advance the input stage unless an OP_END would land on a
    // response that is still held.
    // ---------------------------------------------------------------
    assign is_end      = (r_in.op == OP_END);
    assign fire        = r_in_valid && (!is_end || !r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || fire;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // ---------------------------------------------------------------
    // Per-piece decode. Chain inputs of pieces above the fill mark are held
    // at zero (but the top piece's tail generate, masked at the accept check)
    // so never-written entries stay out of both chains.
    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_piece
            assign skip[j]   = (r_quant[j] == Q_STAR) || (r_quant[j] == Q_OPT);
            assign loops[j]  = (r_quant[j] == Q_STAR) || (r_quant[j] == Q_PLUS);
            assign atom_ok[j] = (r_atom[j] == want_b);
            if (j == 0) begin : g_first
                assign opens[j]     = 1'b1;
                assign wr_sel[j]    = !r_valid[j];
                // First piece always opens an alternative: seed from at_start.
                assign pass_gen[j]  = r_valid[j] && r_at_start;
                assign pass_prop[j] = 1'b0;
            end else begin : g_rest
                assign opens[j]     = r_alt_first[j];
                assign wr_sel[j]    = !r_valid[j] && r_valid[j-1];
                assign pass_gen[j]  = r_valid[j] && (opens[j] ? r_at_start : r_consumed[j-1]);
                assign pass_prop[j] = r_valid[j] && !opens[j] && skip[j-1];
            end
            if (j == N - 1) begin : g_top
                assign last_sel[j]        = r_valid[j];
                assign tail_gen_r[N-1-j]  = 1'b1;
                assign tail_prop_r[N-1-j] = 1'b0;
            end else begin : g_below
                assign last_sel[j]        = r_valid[j] && !r_valid[j+1];
                // End of alternative is reached after piece j when j is the last
                // stored piece, the next piece opens an alternative, or the
                // remaining pieces of this alternative can all be skipped.
                assign tail_gen_r[N-1-j]  = r_valid[j] && (last_sel[j] || opens[j+1]);
                assign tail_prop_r[N-1-j] = r_valid[j+1] && skip[j+1];
            end
            assign tail[j] = tail_r[N-1-j];
        end
    endgenerate

    // Forward closure: which pieces may take the next character.
    arnm_carry_chain #(.W(N)) u_pass_chain (
        .i_gen   (pass_gen),
        .i_prop  (pass_prop),
        .o_carry (pass)
    );

    // Backward closure, run on the bit-reversed vectors.
    arnm_carry_chain #(.W(N)) u_tail_chain (
        .i_gen   (tail_gen_r),
        .i_prop  (tail_prop_r),
        .o_carry (tail_r)
    );

    assign want_b    = (r_in.ch == CH_B);
    assign ch_ab     = (r_in.ch == CH_A) || (r_in.ch == CH_B);
    assign ch_quant  = (r_in.ch == CH_STAR) || (r_in.ch == CH_PLUS) || (r_in.ch == CH_QMARK);
    assign full      = r_valid[N-1];
    assign next_cons = r_valid & (pass | (r_consumed & loops)) & atom_ok;

    always_comb begin
        case (r_in.ch)
            CH_STAR: quant_code = Q_STAR;
            CH_PLUS: quant_code = Q_PLUS;
            default: quant_code = Q_OPT;
        endcase
    end

    assign hit = (r_at_start && (r_empty_alt || !r_alt_has))
              || (|(r_consumed & tail & r_valid))
              || (r_at_start && (|(opens & skip & tail & r_valid)));

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.data;
        end
    end

    // ---------------------------------------------------------------
    // Pattern store payload: write a new atom at the fill mark, or attach
    // a quantifier to the last stored piece.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (fire && r_in.op == OP_PAT) begin
                if (ch_ab && wr_sel[k]) begin
                    r_atom[k]      <= want_b;
                    r_quant[k]     <= Q_NONE;
                    r_alt_first[k] <= !r_alt_has;
                end else if (ch_quant && r_last_atom && !r_ovf && last_sel[k]) begin
                    r_quant[k] <= quant_code;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Control state and response register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_empty_alt <= 1'b0;
            r_last_atom <= 1'b0;
            r_alt_has   <= 1'b0;
            r_ovf       <= 1'b0;
            r_consumed  <= '0;
            r_at_start  <= 1'b1;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load on an OP_END, hold while stalled, drop once taken.
            r_out_valid <= (fire && is_end) || (r_out_valid && !o_rsp.ready);
            if (fire) begin
                case (r_in.op)
                    OP_CLEAR: begin
                        r_valid     <= '0;
                        r_empty_alt <= 1'b0;
                        r_last_atom <= 1'b0;
                        r_alt_has   <= 1'b0;
                        r_ovf       <= 1'b0;
                        r_consumed  <= '0;
                        r_at_start  <= 1'b1;
                        r_bad       <= 1'b0;
                    end
                    OP_PAT: begin
                        if (ch_ab) begin
                            if (full) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_valid    <= r_valid | wr_sel;
                                r_consumed <= r_consumed & ~wr_sel;
                            end
                            r_alt_has   <= 1'b1;
                            r_last_atom <= 1'b1;
                        end else if (r_in.ch == CH_BAR) begin
                            if (!r_alt_has) begin
                                r_empty_alt <= 1'b1;
                            end
                            r_alt_has   <= 1'b0;
                            r_last_atom <= 1'b0;
                        end else begin
                            r_last_atom <= 1'b0;
                        end
                    end
                    OP_START: begin
                        r_consumed <= '0;
                        r_at_start <= 1'b1;
                        r_bad      <= 1'b0;
                    end
                    OP_SUBJ: begin
                        // Any other byte is a sticky reject until restart.
                        if (!ch_ab) begin
                            r_bad <= 1'b1;
                        end else if (!r_bad) begin
                            r_consumed <= next_cons;
                            r_at_start <= 1'b0;
                        end
                    end
                    OP_END: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (fire && is_end) begin
            r_out.matched          <= hit && !r_bad;
            r_out.pattern_overflow <= r_ovf;
        end
    end

endmodule

// ----- design/arnm_checker.sv -----
// Port-level checks of the regex matcher, bound to its top level.
// Depends on arnm_pkg for the request codes.
module arnm_checker import arnm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic [2:0] i_req_op,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input t_rsp       i_rsp_data
);

    // A held response keeps its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data)))
        else $error("response dropped or changed while stalled");

    // Reset drops any pending response.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // A fresh response must trace back to an accepted end-of-subject request.
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |->
            $past(i_req_valid && i_req_ready && (i_req_op == OP_END), 2))
        else $error("response without a matching end request");

    // Requests are never back-pressured unless a response is held.
    a_req_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_rsp_valid || i_rsp_ready) |-> i_req_ready)
        else $error("request stalled with the response side free");

endmodule

bind ab_regex_nfa_matcher arnm_checker u_arnm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_op    (i_req.data.op),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// ----- dv/tb.sv -----
// Self-checking testbench for the {a,b} regex matcher: directed table, then random requests.
// Depends on arnm_pkg and the arnm_req_if / arnm_rsp_if channel interfaces.
module tb;
    import arnm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPIECE      = 32;
    localparam int RST_CYCLES  = 11;
    localparam int DIR_N       = 28;
    localparam int RAND_ITEMS  = 1200;
    localparam int TAIL_CYCLES = 8;
    localparam longint TIMEOUT_NS = 2_000_000;

    // Op codes the block ignores.
    localparam logic [2:0] OP_RSV5 = 3'd5;
    localparam logic [2:0] OP_RSV7 = 3'd7;

    // One planned request; fixed marks a row whose response is typed in the table.
    typedef struct packed {
        t_req req;
        logic fixed;
        t_rsp rsp;
    } t_item;

    // Receiver stall patterns.
    typedef enum int {RX_OPEN, RX_COIN, RX_TRICKLE, RX_BEAT} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    arnm_req_if req_ch();
    arnm_rsp_if rsp_ch();

    ab_regex_nfa_matcher #(.MAX_PIECES(NPIECE)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Pattern and subject state of the predictor.
    // ------------------------------------------------------------------
    logic              pc_atom  [NPIECE];   // 1 = 'b'
    t_quant            pc_quant [NPIECE];
    logic              pc_first [NPIECE];   // piece opens an alternative
    int                pc_count;
    logic [NPIECE-1:0] hit_vec;             // pieces that took the last subject char
    logic              fresh;               // no subject char taken yet
    logic              rejected;            // sticky bad subject char
    logic              empty_alt;
    logic              after_atom;
    logic              alt_nonempty;
    logic              dropped;             // pieces lost to capacity

    t_item dir_tab [DIR_N];
    t_item plan [$];
    t_rsp  q_expected [$];

    int issued;
    int burst_left;
    int gap_left;
    int rst_cnt;
    int n_err;
    int n_results;
    int n_match;
    int n_ovf;

    t_rx_mode stall_mode;
    int       seg_left;
    int       phase;

    function automatic bit is_skippable(int j);
        return pc_quant[j] == Q_STAR || pc_quant[j] == Q_OPT;
    endfunction

    function automatic bit opens_alt(int j);
        return j == 0 || pc_first[j];
    endfunction

    // Advance the predicted matcher by one request; return the response it causes.
    function automatic void nfa_step(input t_req r, output bit has_rsp, output t_rsp rsp);
        logic [NPIECE-1:0] nxt;
        logic pass;
        logic entry;
        logic tail;
        logic hit;
        logic want;
        int   k;
        has_rsp = 1'b0;
        rsp     = '0;
        case (r.op)
            OP_CLEAR: begin
                pc_count     = 0;
                empty_alt    = 1'b0;
                after_atom   = 1'b0;
                alt_nonempty = 1'b0;
                dropped      = 1'b0;
                hit_vec      = '0;
                fresh        = 1'b1;
                rejected     = 1'b0;
            end
            OP_PAT: begin
                if (r.ch == CH_A || r.ch == CH_B) begin
                    if (pc_count < NPIECE) begin
                        pc_atom[pc_count]  = (r.ch == CH_B);
                        pc_quant[pc_count] = Q_NONE;
                        pc_first[pc_count] = !alt_nonempty;
                        hit_vec[pc_count]  = 1'b0;
                        pc_count++;
                    end else begin
                        dropped = 1'b1;
                    end
                    alt_nonempty = 1'b1;
                    after_atom   = 1'b1;
                end else if (r.ch == CH_STAR || r.ch == CH_PLUS || r.ch == CH_QMARK) begin
                    // attach only directly behind a stored atom
                    if (after_atom && !dropped && pc_count > 0) begin
                        if (r.ch == CH_STAR)
                            pc_quant[pc_count-1] = Q_STAR;
                        else if (r.ch == CH_PLUS)
                            pc_quant[pc_count-1] = Q_PLUS;
                        else
                            pc_quant[pc_count-1] = Q_OPT;
                    end
                    after_atom = 1'b0;
                end else if (r.ch == CH_BAR) begin
                    if (!alt_nonempty)
                        empty_alt = 1'b1;
                    alt_nonempty = 1'b0;
                    after_atom   = 1'b0;
                end else begin
                    after_atom = 1'b0;
                end
            end
            OP_START: begin
                hit_vec  = '0;
                fresh    = 1'b1;
                rejected = 1'b0;
            end
            OP_SUBJ: begin
                if (r.ch != CH_A && r.ch != CH_B) begin
                    rejected = 1'b1;
                end else if (!rejected) begin
                    want = (r.ch == CH_B);
                    pass = 1'b0;
                    nxt  = hit_vec;
                    for (k = 0; k < pc_count; k++) begin
                        if (opens_alt(k))
                            pass = fresh;
                        else
                            pass = hit_vec[k-1] || (pass && is_skippable(k-1));
                        entry = pass ||
                                (hit_vec[k] && (pc_quant[k] == Q_STAR || pc_quant[k] == Q_PLUS));
                        nxt[k] = entry && (pc_atom[k] == want);
                    end
                    hit_vec = nxt;
                    fresh   = 1'b0;
                end
            end
            OP_END: begin
                has_rsp = 1'b1;
                hit     = 1'b0;
                tail    = 1'b1;
                if (!rejected) begin
                    if (fresh && (empty_alt || !alt_nonempty))
                        hit = 1'b1;
                    // walk back, tracking whether the end of the alternative is reachable
                    for (k = pc_count - 1; k >= 0; k--) begin
                        if (k + 1 == pc_count || opens_alt(k + 1))
                            tail = 1'b1;
                        else
                            tail = tail && is_skippable(k + 1);
                        if (hit_vec[k] && tail)
                            hit = 1'b1;
                        if (fresh && opens_alt(k) && is_skippable(k) && tail)
                            hit = 1'b1;
                    end
                end
                rsp.matched          = hit;
                rsp.pattern_overflow = dropped;
            end
            default: ;
        endcase
    endfunction

    function automatic void plan_req(logic [2:0] op, logic [7:0] ch);
        t_item it;
        it.req.op = op;
        it.req.ch = ch;
        it.fixed  = 1'b0;
        it.rsp    = '0;
        plan.insert(plan.size(), it);
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and known values on every input from time zero.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : init_state
        int k;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.data     = '0;
        rsp_ch.ready    = 1'b0;
        rst_cnt         = 0;
        issued          = 0;
        burst_left      = 1;
        gap_left        = 0;
        n_err           = 0;
        n_results       = 0;
        n_match         = 0;
        n_ovf           = 0;
        seg_left        = 0;
        phase           = 0;
        stall_mode      = RX_OPEN;
        pc_count        = 0;
        hit_vec         = '0;
        fresh           = 1'b1;
        rejected        = 1'b0;
        empty_alt       = 1'b0;
        after_atom      = 1'b0;
        alt_nonempty    = 1'b0;
        dropped         = 1'b0;
        for (k = 0; k < NPIECE; k++) begin
            pc_atom[k]  = 1'b0;
            pc_quant[k] = Q_NONE;
            pc_first[k] = 1'b0;
        end
    end

    // Hold reset low from the start, then release it for good.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rst_cnt++;
            if (rst_cnt == RST_CYCLES)
                i_rst_n <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Request side and response check. Check the response before
    // predicting the request taken on the same edge, so the oldest
    // expectation is always the one compared.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : req_side
        t_rsp pred;
        t_rsp exp_r;
        bit   has;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (q_expected.size() == 0) begin
                    $display("%0t: unexpected response matched=%0b overflow=%0b",
                             $time, rsp_ch.data.matched, rsp_ch.data.pattern_overflow);
                    n_err++;
                end else begin
                    exp_r = q_expected.pop_front();
                    if (rsp_ch.data.matched !== exp_r.matched) begin
                        $display("%0t: matched expected %0b actual %0b",
                                 $time, exp_r.matched, rsp_ch.data.matched);
                        n_err++;
                    end
                    if (rsp_ch.data.pattern_overflow !== exp_r.pattern_overflow) begin
                        $display("%0t: pattern_overflow expected %0b actual %0b",
                                 $time, exp_r.pattern_overflow, rsp_ch.data.pattern_overflow);
                        n_err++;
                    end
                    n_results++;
                    if (exp_r.matched)
                        n_match++;
                    if (exp_r.pattern_overflow)
                        n_ovf++;
                end
            end

            // Predict the request taken on this edge, then advance the burst.
            if (req_ch.valid && req_ch.ready) begin
                nfa_step(plan[issued].req, has, pred);
                if (has)
                    q_expected.insert(q_expected.size(),
                                      plan[issued].fixed ? plan[issued].rsp : pred);
                issued++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    // a quarter of the bursts follow on with no gap at all
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end

            // Drop valid in a gap, hold or advance it otherwise.
            if (gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (issued < plan.size()) begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= plan[issued].req;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response side: switch between stall patterns in segments of random
    // length so stalls land on every phase of the request stream.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (seg_left == 0) begin
            seg_left   = $urandom_range(20, 200);
            stall_mode = t_rx_mode'($urandom_range(0, 3));
        end else begin
            seg_left--;
        end
        phase++;
        case (stall_mode)
            RX_OPEN:    rsp_ch.ready <= 1'b1;
            RX_COIN:    rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_TRICKLE: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            default:    rsp_ch.ready <= (phase % 5) < 3;
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus plan, then wait for the run to drain and report.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int k;
        int r;
        int len;
        logic [7:0] c;

        // op, ch, typed, matched, overflow
        dir_tab[0]  = {OP_END,   8'h00,    1'b1, 1'b1, 1'b0}; // empty pattern after reset
        dir_tab[1]  = {OP_PAT,   CH_A,     1'b0, 1'b0, 1'b0};
        dir_tab[2]  = {OP_PAT,   CH_STAR,  1'b0, 1'b0, 1'b0};
        dir_tab[3]  = {OP_PAT,   CH_STAR,  1'b0, 1'b0, 1'b0}; // second quantifier skipped
        dir_tab[4]  = {OP_PAT,   CH_BAR,   1'b0, 1'b0, 1'b0};
        dir_tab[5]  = {OP_PAT,   CH_B,     1'b0, 1'b0, 1'b0};
        dir_tab[6]  = {OP_PAT,   CH_PLUS,  1'b0, 1'b0, 1'b0};
        dir_tab[7]  = {OP_PAT,   8'h00,    1'b0, 1'b0, 1'b0}; // stray char
        dir_tab[8]  = {OP_PAT,   CH_QMARK, 1'b0, 1'b0, 1'b0}; // no atom in front
        dir_tab[9]  = {OP_PAT,   CH_BAR,   1'b0, 1'b0, 1'b0};
        dir_tab[10] = {OP_PAT,   CH_BAR,   1'b0, 1'b0, 1'b0}; // empty alternative
        dir_tab[11] = {OP_PAT,   8'hFF,    1'b0, 1'b0, 1'b0}; // stray char
        dir_tab[12] = {OP_END,   8'hFF,    1'b0, 1'b0, 1'b0};
        dir_tab[13] = {OP_START, 8'h00,    1'b0, 1'b0, 1'b0};
        dir_tab[14] = {OP_SUBJ,  CH_A,     1'b0, 1'b0, 1'b0};
        dir_tab[15] = {OP_SUBJ,  CH_A,     1'b0, 1'b0, 1'b0};
        dir_tab[16] = {OP_END,   8'h00,    1'b0, 1'b0, 1'b0};
        dir_tab[17] = {OP_SUBJ,  CH_B,     1'b0, 1'b0, 1'b0}; // subject goes on after end
        dir_tab[18] = {OP_PAT,   CH_B,     1'b0, 1'b0, 1'b0}; // pattern grows mid-subject
        dir_tab[19] = {OP_END,   8'h00,    1'b0, 1'b0, 1'b0};
        dir_tab[20] = {OP_START, 8'hFF,    1'b0, 1'b0, 1'b0};
        dir_tab[21] = {OP_SUBJ,  8'hFF,    1'b0, 1'b0, 1'b0}; // bad subject char
        dir_tab[22] = {OP_END,   8'h00,    1'b1, 1'b0, 1'b0};
        dir_tab[23] = {OP_RSV5,  8'hAA,    1'b0, 1'b0, 1'b0}; // ignored op
        dir_tab[24] = {OP_RSV7,  8'h55,    1'b0, 1'b0, 1'b0}; // ignored op
        dir_tab[25] = {OP_CLEAR, 8'h00,    1'b0, 1'b0, 1'b0};
        dir_tab[26] = {OP_END,   8'h00,    1'b1, 1'b1, 1'b0}; // cleared pattern, empty subject
        dir_tab[27] = {OP_SUBJ,  8'h00,    1'b0, 1'b0, 1'b0}; // reject without a start

        for (k = 0; k < DIR_N; k++)
            plan.insert(plan.size(), dir_tab[k]);

        // Mostly well-formed groups: a pattern load, or a start/chars/end
        // subject; the rest is raw noise over every op and byte.
        while (plan.size() < DIR_N + RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                repeat ($urandom_range(1, 4))
                    plan_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end else if (r < 32) begin
                // now and then append to the current pattern instead of clearing
                if ($urandom_range(0, 4) != 0)
                    plan_req(OP_CLEAR, 8'($urandom_range(0, 255)));
                // a few long loads may run past capacity
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                  : $urandom_range(1, 8);
                repeat (len) begin
                    k = $urandom_range(0, 99);
                    if (k < 50)
                        c = k[0] ? CH_B : CH_A;
                    else if (k < 58)
                        c = CH_STAR;
                    else if (k < 66)
                        c = CH_PLUS;
                    else if (k < 74)
                        c = CH_QMARK;
                    else if (k < 88)
                        c = CH_BAR;
                    else
                        c = 8'($urandom_range(0, 255));
                    plan_req(OP_PAT, c);
                end
            end else begin
                if ($urandom_range(0, 9) != 0)
                    plan_req(OP_START, 8'($urandom_range(0, 255)));
                len = $urandom_range(0, 8);
                repeat (len) begin
                    k = $urandom_range(0, 99);
                    if (k < 94)
                        plan_req(OP_SUBJ, k[0] ? CH_B : CH_A);
                    else if (k < 97)
                        plan_req(OP_SUBJ, 8'($urandom_range(0, 255)));
                    else
                        plan_req(OP_PAT, k[0] ? CH_A : CH_STAR);
                end
                if ($urandom_range(0, 19) != 0)
                    plan_req(OP_END, 8'($urandom_range(0, 255)));
            end
        end

        // Sample on the falling edge, clear of the updates at the rising one.
        @(negedge i_clk);
        while (!i_rst_n || issued < plan.size() || q_expected.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("ran %0d requests (%0d directed), checked %0d responses",
                 issued, DIR_N, n_results);
        $display("%0d responses matched, %0d carried the overflow flag", n_match, n_ovf);
        if (n_err == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #(TIMEOUT_NS);
        $display("tb NOT OK");
        $finish;
    end

endmodule
